### design/bdq_pkg.sv
// shared types and codes for the bounded deque with indexed read
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  // fixed field widths
  localparam int CmdW   = 3;
  localparam int WordW  = 32;
  localparam int IdxW   = 6;
  localparam int StatW  = 2;
  localparam int CountW = 7;

  // command codes
  localparam logic [CmdW-1:0] CMD_ADD_BACK   = 3'd0;
  localparam logic [CmdW-1:0] CMD_ADD_FRONT  = 3'd1;
  localparam logic [CmdW-1:0] CMD_REMOVE     = 3'd2;
  localparam logic [CmdW-1:0] CMD_READ_FRONT = 3'd3;
  localparam logic [CmdW-1:0] CMD_READ_BACK  = 3'd4;
  localparam logic [CmdW-1:0] CMD_READ_AT    = 3'd5;

  // status codes
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_RANGE = 2'd2;
  localparam logic [StatW-1:0] ST_FULL  = 2'd3;

  // input item
  typedef struct packed {
    logic [CmdW-1:0]         cmd;
    logic signed [WordW-1:0] value;
    logic [IdxW-1:0]         index;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [WordW-1:0] data;
    logic [StatW-1:0]        status;
    logic [CountW-1:0]       count;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

`default_nettype wire

### design/bdq_ctrl.sv
// controller state machine: handshakes and sequencing of one item
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output bdq_pkg::dp_cmd_t dp_cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_ACCESS = 3'b010,
    S_RESP   = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // a new item may enter while the last result is taken
  assign in_ready_o  = (state_q == S_IDLE) || ((state_q == S_RESP) && out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_RESP);

  assign dp_cmd_o.load = accept;
  assign dp_cmd_o.exec = (state_q == S_ACCESS);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_ACCESS;
      end
      S_ACCESS: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) state_d = accept ? S_ACCESS : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### design/bdq_datapath.sv
// datapath: slot memory, front pointer, occupancy and result registers
`timescale 1ns / 1ps
`default_nettype none

module bdq_datapath #(
  parameter int DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bdq_pkg::dp_cmd_t  dp_cmd_i,
  input  wire bdq_pkg::in_item_t in_item_i,
  output bdq_pkg::out_item_t     out_item_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OccW = $clog2(DEPTH + 1);
  localparam int CmpW = (OccW > bdq_pkg::IdxW) ? OccW : bdq_pkg::IdxW;

  // latched item
  logic [bdq_pkg::CmdW-1:0]  cmd_q;
  logic [bdq_pkg::WordW-1:0] value_q;
  logic [bdq_pkg::IdxW-1:0]  index_q;

  // deque state
  logic [PtrW-1:0] fp_q, fp_d;
  logic [OccW-1:0] occ_q, occ_d;

  // result state
  logic [bdq_pkg::StatW-1:0] status_q, status_d;
  logic                      rd_ok_q, rd_ok_d;
  logic [bdq_pkg::WordW-1:0] rdata_q;

  logic [bdq_pkg::WordW-1:0] mem_q [DEPTH];

  logic            full, empty, we;
  logic [PtrW-1:0] offset, fp_inc, fp_dec, addr;
  logic [PtrW:0]   sum;

  // latch the accepted item
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      cmd_q   <= in_item_i.cmd;
      value_q <= in_item_i.value;
      index_q <= in_item_i.index;
    end
  end

  assign full   = (occ_q == OccW'(DEPTH));
  assign empty  = (occ_q == '0);
  assign fp_inc = (fp_q == PtrW'(DEPTH - 1)) ? '0 : fp_q + PtrW'(1);
  assign fp_dec = (fp_q == '0) ? PtrW'(DEPTH - 1) : fp_q - PtrW'(1);

  // offset from front; always below depth whenever it is used
  always_comb begin
    case (cmd_q)
      bdq_pkg::CMD_ADD_BACK:  offset = PtrW'(occ_q);
      bdq_pkg::CMD_READ_BACK: offset = PtrW'(occ_q - OccW'(1));
      bdq_pkg::CMD_READ_AT:   offset = PtrW'(index_q);
      default:                offset = '0;
    endcase
  end

  // circular address: one compare and subtract
  assign sum = {1'b0, fp_q} + {1'b0, offset};

  always_comb begin
    if (sum >= (PtrW + 1)'(DEPTH)) begin
      addr = PtrW'(sum - (PtrW + 1)'(DEPTH));
    end else begin
      addr = PtrW'(sum);
    end
    if (cmd_q == bdq_pkg::CMD_ADD_FRONT) addr = fp_dec;
  end

  // command decode
  always_comb begin
    fp_d     = fp_q;
    occ_d    = occ_q;
    status_d = bdq_pkg::ST_OK;
    rd_ok_d  = 1'b0;
    we       = 1'b0;
    case (cmd_q)
      bdq_pkg::CMD_ADD_BACK: begin
        if (full) begin
          status_d = bdq_pkg::ST_FULL;
        end else begin
          we    = 1'b1;
          occ_d = occ_q + OccW'(1);
        end
      end
      bdq_pkg::CMD_ADD_FRONT: begin
        if (full) begin
          status_d = bdq_pkg::ST_FULL;
        end else begin
          we    = 1'b1;
          fp_d  = fp_dec;
          occ_d = occ_q + OccW'(1);
        end
      end
      bdq_pkg::CMD_REMOVE: begin
        if (empty) begin
          status_d = bdq_pkg::ST_EMPTY;
        end else begin
          fp_d  = fp_inc;
          occ_d = occ_q - OccW'(1);
        end
      end
      bdq_pkg::CMD_READ_FRONT, bdq_pkg::CMD_READ_BACK: begin
        if (empty) begin
          status_d = bdq_pkg::ST_EMPTY;
        end else begin
          rd_ok_d = 1'b1;
        end
      end
      bdq_pkg::CMD_READ_AT: begin
        if (empty) begin
          status_d = bdq_pkg::ST_EMPTY;
        end else if (CmpW'(index_q) >= CmpW'(occ_q)) begin
          status_d = bdq_pkg::ST_RANGE;
        end else begin
          rd_ok_d = 1'b1;
        end
      end
      default: begin
        status_d = bdq_pkg::ST_OK;
      end
    endcase
  end

  // slot memory, one access per item
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.exec) begin
      if (we) mem_q[addr] <= value_q;
      rdata_q <= mem_q[addr];
    end
  end

  // deque and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q     <= '0;
      occ_q    <= '0;
      status_q <= bdq_pkg::ST_OK;
      rd_ok_q  <= 1'b0;
    end else if (dp_cmd_i.exec) begin
      fp_q     <= fp_d;
      occ_q    <= occ_d;
      status_q <= status_d;
      rd_ok_q  <= rd_ok_d;
    end
  end

  assign out_item_o.data   = rd_ok_q ? rdata_q : '0;
  assign out_item_o.status = status_q;
  assign out_item_o.count  = bdq_pkg::CountW'(occ_q);

endmodule

`default_nettype wire

### design/bounded_deque_with_indexed_read_unit.sv
// Bounded deque of signed 32-bit words with indexed read, top level.
// Input channel (in_valid_i / in_ready_o / in_item_i) takes one command per
// item: add back, add front, remove front, read front, read back, or read at
// an index counted from the front. Output channel (out_valid_o / out_ready_i /
// out_item_o) returns exactly one result per item: read data, status and the
// word count after the command.
// Sequencing: an accepted item is latched, executed in the access state, and
// its result is registered and held valid in the result state. The
// controller holds one item at a time (accept, memory access, result), and a
// new item is taken in the same cycle the held result is taken, so a new item
// is never taken while the last one is still in its memory access.
// Reset empties the deque (front pointer and count cleared); slot contents
// are left as they are and can only be read once written.
// If the receiver stalls, the result is held on out_item_o and in_ready_o
// stays low until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_indexed_read_unit #(
  parameter int DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire bdq_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output bdq_pkg::out_item_t     out_item_o
);

  bdq_pkg::dp_cmd_t dp_cmd;

  // sequencing and handshakes
  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd)
  );

  // storage and command execution
  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dp_cmd_i   (dp_cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
